/* rtl/gpsl_pkg.sv */
// Shared types, constants and helper functions for the gesture pulse slew limiter.
// No dependencies; imported by gpsl_front and gesture_pulse_slew_limiter.
package gpsl_pkg;

    // Gesture codes
    localparam logic [2:0] GEST_UNKNOWN   = 3'd0;
    localparam logic [2:0] GEST_OPEN_PALM = 3'd1;
    localparam logic [2:0] GEST_POINT     = 3'd2;
    localparam logic [2:0] GEST_V_SIGN    = 3'd3;
    localparam logic [2:0] GEST_FIST      = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_SOURCE_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_COMMAND_PULSE  = 2'd1;
    localparam logic [1:0] REG_FRAME_PERIOD   = 2'd2;
    localparam logic [1:0] REG_AXIS_RATE      = 2'd3;

    // Configuration reset values
    localparam logic [23:0] TIMEOUT_RESET = 24'd500000;
    localparam logic [23:0] PULSE_RESET   = 24'd1000000;
    localparam logic [23:0] PERIOD_RESET  = 24'd20000;
    localparam logic [15:0] RATE_RESET    = 16'd600;

    // Confidence threshold 0.75 in Q1.10
    localparam logic [10:0] CONF_THRESHOLD = 11'd768;
    localparam logic [7:0]  PCT_MAX        = 8'd100;

    // Axis limit and step clamp
    localparam logic signed [9:0] AXIS_LIMIT = 10'sd300;
    localparam logic [9:0]        STEP_MAX   = 10'd1000;
    localparam logic [9:0]        STEP_MIN   = 10'd1;

    // Products at or above 1e9 (a quotient of one thousand) clamp to the max step
    localparam logic [39:0] BIG_PRODUCT = 40'd1000000000;
    // floor(x / 1e6) = (x * RECIP_M) >> RECIP_SHIFT, exact for x < 2^30
    localparam logic [30:0] RECIP_M     = 31'd1125899907;
    localparam int          RECIP_SHIFT = 50;

    typedef struct packed {
        logic [23:0] source_timeout;
        logic [23:0] command_pulse;
        logic [23:0] frame_period;
        logic [15:0] axis_rate;
    } cfg_t;

    typedef struct packed {
        logic        gesture_active;
        logic [2:0]  active_gesture;
        logic [2:0]  observed_gesture;
        logic        confidence_finite;
        logic [10:0] confidence_q10;
        logic [63:0] source_time;
        logic [63:0] send_time;
    } in_beat_t;

    // Per-frame decisions carried down the front pipeline
    typedef struct packed {
        logic        fault;
        logic        active;
        logic [2:0]  gesture;
        logic [6:0]  pct;
        logic [63:0] pulse_end;
        logic        pulse_live;
        logic [63:0] send_time;
    } frame_info_t;

    // Move cur toward tgt by step without overshoot
    function automatic logic signed [9:0] slew(input logic signed [9:0] cur,
                                               input logic signed [9:0] tgt,
                                               input logic [9:0] step);
        logic signed [11:0] c;
        logic signed [11:0] t;
        logic signed [11:0] s;
        logic signed [11:0] up;
        logic signed [11:0] dn;
        logic signed [9:0]  r;
        c  = {{2{cur[9]}}, cur};
        t  = {{2{tgt[9]}}, tgt};
        s  = {2'b00, step};
        up = c + s;
        dn = c - s;
        if (c == t) begin
            r = cur;
        end else if (t > c) begin
            r = (up > t) ? tgt : up[9:0];
        end else begin
            r = (dn < t) ? tgt : dn[9:0];
        end
        return r;
    endfunction

endpackage

/* rtl/gesture_pulse_slew_limiter.sv */
// Gesture pulse slew limiter: top level with configuration, frame state and result register.
// Depends on gpsl_pkg and gpsl_front.
//
// One s_ beat carries a frame event (gesture snapshot plus source and send
// timestamps); one m_ beat carries the resulting control frame. Every input
// beat produces exactly one output beat, in order.
// Path: a beat accepted on s_ passes the input register, three arithmetic
// stages, then the state update that loads the output register, and shows
// on m_ from that register.
// Throughput: one beat per cycle while m_ is not stalled; the only loop is
// the roll/pitch/command state update in the last stage.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr at the clock
// edge; write only while no frame is in flight.
// Reset (aresetn low at a clock edge) clears the pipeline, the frame state
// and the beat counter, and restores the register defaults.
// When m_tready is low with m_tvalid high, the whole pipeline holds and
// s_tready drops; nothing is dropped or duplicated.
module gesture_pulse_slew_limiter
    import gpsl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] gesture_active, [3:1] active_gesture, [6:4] observed_gesture,
    // [7] confidence_finite, [18:8] confidence_q10, [82:19] source_time,
    // [146:83] send_time, [151:147] zero
    input  logic [151:0] s_tdata,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [0] frame_valid, [3:1] command_id, [10:4] confidence_pct,
    // [42:11] beat_count, [52:43] roll_out, [62:53] pitch_out, [63] zero
    output logic [63:0]  m_tdata
);

    cfg_t        cfg_reg;
    in_beat_t    in_beat;
    logic        adv;
    logic        info_valid;
    frame_info_t info;
    logic [9:0]  step;

    // Unpack the input beat
    assign in_beat.gesture_active    = s_tdata[0];
    assign in_beat.active_gesture    = s_tdata[3:1];
    assign in_beat.observed_gesture  = s_tdata[6:4];
    assign in_beat.confidence_finite = s_tdata[7];
    assign in_beat.confidence_q10    = s_tdata[18:8];
    assign in_beat.source_time       = s_tdata[82:19];
    assign in_beat.send_time         = s_tdata[146:83];

    // Whole pipeline moves when the result register is free or being taken
    logic m_valid_reg;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    gpsl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .in_beat    (in_beat),
        .cfg        (cfg_reg),
        .info_valid (info_valid),
        .info       (info),
        .step       (step)
    );

    // Frame state
    logic [31:0]       beat_reg, beat_next;
    logic signed [9:0] roll_reg, roll_next;
    logic signed [9:0] pitch_reg, pitch_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [6:0]        held_pct_reg, held_pct_next;
    logic              edge_reg, edge_next;
    logic [63:0]       pulse_end_reg, pulse_end_next;

    // Result register
    logic              m_frame_valid_reg, m_frame_valid_next;
    logic [2:0]        m_command_id_reg, m_command_id_next;
    logic [6:0]        m_pct_reg, m_pct_next;
    logic signed [9:0] m_roll_reg;
    logic signed [9:0] m_pitch_reg;

    logic              new_edge;
    logic              live;
    logic signed [9:0] roll_base, pitch_base;
    logic signed [9:0] roll_tgt, pitch_tgt;

    // Apply one frame to the state
    always_comb begin
        beat_next = beat_reg + 32'd1;
        new_edge  = info.active && (!edge_reg || (cmd_reg != info.gesture));
        roll_tgt  = '0;
        pitch_tgt = '0;

        if (info.fault) begin
            roll_next          = '0;
            pitch_next         = '0;
            cmd_next           = GEST_UNKNOWN;
            held_pct_next      = '0;
            edge_next          = 1'b0;
            pulse_end_next     = '0;
            live               = 1'b0;
            roll_base          = '0;
            pitch_base         = '0;
            m_frame_valid_next = 1'b0;
            m_command_id_next  = GEST_UNKNOWN;
            m_pct_next         = '0;
        end else begin
            held_pct_next  = info.active ? info.pct : held_pct_reg;
            cmd_next       = new_edge ? info.gesture : cmd_reg;
            pulse_end_next = new_edge ? info.pulse_end : pulse_end_reg;
            live           = new_edge ? info.pulse_live : (info.send_time < pulse_end_reg);
            roll_base      = new_edge ? 10'sd0 : roll_reg;
            pitch_base     = new_edge ? 10'sd0 : pitch_reg;
            edge_next      = info.active;

            // Target while the pulse lasts; other codes give zero
            if (live) begin
                if (cmd_next == GEST_OPEN_PALM) begin
                    pitch_tgt = -AXIS_LIMIT;
                end else if (cmd_next == GEST_POINT) begin
                    pitch_tgt = AXIS_LIMIT;
                end else if (cmd_next == GEST_V_SIGN) begin
                    roll_tgt = -AXIS_LIMIT;
                end
            end

            roll_next  = slew(roll_base, roll_tgt, step);
            pitch_next = slew(pitch_base, pitch_tgt, step);

            m_frame_valid_next = 1'b1;
            if ((roll_next != 10'sd0) || (pitch_next != 10'sd0)) begin
                m_command_id_next = cmd_next;
                m_pct_next        = held_pct_next;
            end else begin
                m_command_id_next = GEST_UNKNOWN;
                m_pct_next        = '0;
            end
        end
    end

    // Configuration, state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_timeout <= TIMEOUT_RESET;
            cfg_reg.command_pulse  <= PULSE_RESET;
            cfg_reg.frame_period   <= PERIOD_RESET;
            cfg_reg.axis_rate      <= RATE_RESET;
            beat_reg      <= '0;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            cmd_reg       <= GEST_UNKNOWN;
            held_pct_reg  <= '0;
            edge_reg      <= 1'b0;
            pulse_end_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_SOURCE_TIMEOUT: cfg_reg.source_timeout <= cfg_wdata;
                    REG_COMMAND_PULSE:  cfg_reg.command_pulse  <= cfg_wdata;
                    REG_FRAME_PERIOD:   cfg_reg.frame_period   <= cfg_wdata;
                    REG_AXIS_RATE:      cfg_reg.axis_rate      <= cfg_wdata[15:0];
                endcase
            end
            if (adv) begin
                m_valid_reg <= info_valid;
            end
            if (adv && info_valid) begin
                beat_reg      <= beat_next;
                roll_reg      <= roll_next;
                pitch_reg     <= pitch_next;
                cmd_reg       <= cmd_next;
                held_pct_reg  <= held_pct_next;
                edge_reg      <= edge_next;
                pulse_end_reg <= pulse_end_next;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (adv && info_valid) begin
            m_frame_valid_reg <= m_frame_valid_next;
            m_command_id_reg  <= m_command_id_next;
            m_pct_reg         <= m_pct_next;
            m_roll_reg        <= roll_next;
            m_pitch_reg       <= pitch_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_pitch_reg, m_roll_reg, beat_reg, m_pct_reg,
                       m_command_id_reg, m_frame_valid_reg};

    // Channels never leave the axis range
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_roll_reg <= AXIS_LIMIT) && (m_roll_reg >= -AXIS_LIMIT)
                     && (m_pitch_reg <= AXIS_LIMIT) && (m_pitch_reg >= -AXIS_LIMIT))
        else $error("axis output out of range");

    // Fault frames carry zero channels and no command
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_frame_valid_reg) |->
            (m_roll_reg == 10'sd0) && (m_pitch_reg == 10'sd0)
            && (m_command_id_reg == GEST_UNKNOWN) && (m_pct_reg == 7'd0))
        else $error("fault frame not cleared");

    // Idle channels report no command
    a_idle_no_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_roll_reg == 10'sd0) && (m_pitch_reg == 10'sd0)) |->
            (m_command_id_reg == GEST_UNKNOWN) && (m_pct_reg == 7'd0))
        else $error("command reported with idle channels");

    // Beat counter steps by one per delivered frame
    a_beat_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && info_valid) |=> (beat_reg == $past(beat_reg) + 32'd1))
        else $error("beat counter did not advance");

    // Stalled result holds the frame state
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(roll_reg) && $stable(pitch_reg) && $stable(beat_reg))
        else $error("state changed during stall");

endmodule

/* rtl/gpsl_front.sv */
// Front pipeline of the slew limiter: input register, frame checks, elapsed time,
// slew step (rate * elapsed / 1e6 by reciprocal multiply). Depends on gpsl_pkg.
module gpsl_front
    import gpsl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        adv,
    input  logic        in_valid,
    input  in_beat_t    in_beat,
    input  cfg_t        cfg,
    output logic        info_valid,
    output frame_info_t info,
    output logic [9:0]  step
);

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [63:0] last_send_reg;

    in_beat_t    beat1_reg;
    logic [63:0] prev1_reg;

    frame_info_t info2_reg, info2_next;
    logic [23:0] elapsed2_reg, elapsed2_next;

    frame_info_t info3_reg;
    logic [39:0] prod3_reg, prod3_next;

    frame_info_t info4_reg;
    logic [9:0]  step4_reg, step4_next;

    // Stage 2: freshness, ordering, activity, percent, pulse end, elapsed
    logic [63:0] src_age;
    logic [63:0] send_gap;
    logic        fresh, ordered, active;
    logic [17:0] pct_raw;
    logic [7:0]  pct_wide;
    logic [64:0] pulse_sum;
    logic [63:0] pulse_sat;

    always_comb begin
        src_age  = beat1_reg.send_time - beat1_reg.source_time;
        send_gap = beat1_reg.send_time - prev1_reg;

        fresh = (beat1_reg.source_time != 64'd0)
             && (beat1_reg.send_time >= beat1_reg.source_time)
             && (src_age[63:24] == 40'd0)
             && (src_age[23:0] <= cfg.source_timeout);
        ordered = (prev1_reg == 64'd0) || (beat1_reg.send_time >= prev1_reg);
        active  = beat1_reg.gesture_active
               && (beat1_reg.active_gesture != GEST_UNKNOWN)
               && (beat1_reg.observed_gesture == beat1_reg.active_gesture)
               && beat1_reg.confidence_finite
               && (beat1_reg.confidence_q10 >= CONF_THRESHOLD);

        // round half up, saturate at 100, zero when confidence is not finite
        pct_raw  = {7'd0, beat1_reg.confidence_q10} * 18'd100 + 18'd512;
        pct_wide = pct_raw[17:10];
        if (!beat1_reg.confidence_finite) begin
            pct_wide = 8'd0;
        end else if (pct_wide > PCT_MAX) begin
            pct_wide = PCT_MAX;
        end

        pulse_sum = {1'b0, beat1_reg.send_time} + {41'd0, cfg.command_pulse};
        pulse_sat = pulse_sum[64] ? {64{1'b1}} : pulse_sum[63:0];

        info2_next.fault      = !fresh || !ordered
                             || (active && (beat1_reg.active_gesture == GEST_FIST));
        info2_next.active     = active;
        info2_next.gesture    = beat1_reg.active_gesture;
        info2_next.pct        = pct_wide[6:0];
        info2_next.pulse_end  = pulse_sat;
        info2_next.pulse_live = beat1_reg.send_time < pulse_sat;
        info2_next.send_time  = beat1_reg.send_time;

        // elapsed capped at the timeout, frame period with no earlier frame or out of order
        if ((prev1_reg != 64'd0) && (beat1_reg.send_time >= prev1_reg)) begin
            if ((send_gap[63:24] != 40'd0) || (send_gap[23:0] > cfg.source_timeout)) begin
                elapsed2_next = cfg.source_timeout;
            end else begin
                elapsed2_next = send_gap[23:0];
            end
        end else begin
            elapsed2_next = cfg.frame_period;
        end
    end

    // Stage 3: rate times elapsed
    assign prod3_next = {24'd0, cfg.axis_rate} * {16'd0, elapsed2_reg};

    // Stage 4: divide by one million and clamp to [1, 1000]
    logic [60:0] recip_prod;
    logic [10:0] quo;

    always_comb begin
        recip_prod = {31'd0, prod3_reg[29:0]} * {30'd0, RECIP_M};
        quo        = recip_prod[RECIP_SHIFT +: 11];
        if (prod3_reg >= BIG_PRODUCT) begin
            step4_next = STEP_MAX;
        end else if (quo == 11'd0) begin
            step4_next = STEP_MIN;
        end else begin
            step4_next = quo[9:0];
        end
    end

    // Advance the valid chain and the last send time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            last_send_reg <= 64'd0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (in_valid) begin
                last_send_reg <= in_beat.send_time;
            end
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            beat1_reg    <= in_beat;
            prev1_reg    <= last_send_reg;
            info2_reg    <= info2_next;
            elapsed2_reg <= elapsed2_next;
            info3_reg    <= info2_reg;
            prod3_reg    <= prod3_next;
            info4_reg    <= info3_reg;
            step4_reg    <= step4_next;
        end
    end

    assign info_valid = v4_reg;
    assign info       = info4_reg;
    assign step       = step4_reg;

endmodule
